/* hdl/aes_block_modes_ecb_cbc_ctr_core_assert.svh */
// Assertion macros for the AES block-mode core
`ifndef AES_BLOCK_MODES_ECB_CBC_CTR_CORE_ASSERT_SVH
`define AES_BLOCK_MODES_ECB_CBC_CTR_CORE_ASSERT_SVH
`define AES_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define AES_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* hdl/abm_pkg.sv */
// Package: types, constants and cipher functions for the AES block-mode core
`timescale 1ns / 1ps
`default_nettype none
package abm_pkg;
  localparam int unsigned RoundsDefault = 10;
  localparam int unsigned BlockBytes = 16;
  localparam logic [1:0] ModeData = 2'd0;
  localparam logic [1:0] ModeKey = 2'd1;
  localparam logic [1:0] ModeRestart = 2'd2;
  localparam logic [1:0] ChainEcb = 2'd0;
  localparam logic [1:0] ChainCbc = 2'd1;
  localparam logic [1:0] ChainCtr = 2'd2;
  localparam logic [1:0] CfgChainMode = 2'd0;
  localparam logic [1:0] CfgDirection = 2'd1;
  localparam logic [1:0] CfgIvHigh = 2'd2;
  localparam logic [1:0] CfgIvLow = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  key_index;
    logic [63:0] word_high;
    logic [63:0] word_low;
    logic [4:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // state byte i sits at bits [127-8i -: 8]
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) t[r+4*c] = b[r+4*((c+r)%4)];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = last ? t[4*c+r] :
          (xt(t[4*c+r]) ^ xt(t[4*c+(r+1)%4]) ^ t[4*c+(r+1)%4]
           ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4]);
    enc_round = o;
  endfunction

  // shift, sub, then key add; mix afterward unless last
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a [16];
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) t[r+4*((c+r)%4)] = inv_sbox(s[127-8*(r+4*c) -: 8]);
    for (int i = 0; i < 16; i++) a[i] = t[i] ^ k[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = last ? a[4*c+r] :
          (gmul(a[4*c+r], 8'd14) ^ gmul(a[4*c+(r+1)%4], 8'd11)
           ^ gmul(a[4*c+(r+2)%4], 8'd13) ^ gmul(a[4*c+(r+3)%4], 8'd9));
    dec_round = o;
  endfunction
endpackage
`default_nettype wire

/* hdl/abm_ram.sv */
// Generic single-port-write, single-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module abm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/aes_block_modes_ecb_cbc_ctr_core.sv */
// AES block engine with ECB, CBC and CTR chaining, round keys kept in one 64-bit key RAM
// Data word: each round key is read as two halves, so a round takes two RAM reads; the
//   next word is accepted as the result appears.
// Key-load words make two RAM writes, high half then low half; a full output register
//   holds the engine at its last round until the pending result is taken.
// Reset clears control, chain, output valid and configuration; the key RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_block_modes_ecb_cbc_ctr_core_assert.svh"
module aes_block_modes_ecb_cbc_ctr_core
  import abm_pkg::*;
#(
  parameter int unsigned ROUNDS = RoundsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);
  localparam int unsigned KeyWords = 2 * (ROUNDS + 1);
  localparam int unsigned AW = $clog2(KeyWords);
  localparam int unsigned CW = $clog2(KeyWords + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun = 2'd1;
  localparam logic [1:0] StKeyLo = 2'd2;

  logic [1:0] st_q, st_d;
  logic [1:0] chain_mode_q;
  logic       dir_q;
  logic [127:0] iv_q, chain_q, chain_d;
  logic [127:0] s_q, s_d, blk_q;
  logic [63:0]  khi_q, khi_d;
  logic [4:0]   cnt_q;
  logic         dec_q, ctr_q, cbc_q;
  logic [CW-1:0] step_q, step_d, rstep;
  logic [AW-1:0] raddr, ram_waddr, klo_addr_q;
  logic [63:0]  rdata, ram_wdata, klo_q;
  logic         accept, key_accept, out_free, ram_we;
  logic         out_valid_q, out_valid_d;
  out_word_t    res_q, res_d;
  logic [127:0] kfull, s_fin, res_blk, blk_in;
  logic         ctr_in, cbc_in;

  assign in_ready_o = (st_q == StIdle);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = res_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign key_accept = accept && in_data_i.mode == ModeKey && in_data_i.key_index <= 4'(ROUNDS);

  // key load writes the high half at accept, the low half the next cycle
  always_comb begin
    ram_we = key_accept;
    ram_waddr = AW'({in_data_i.key_index, 1'b0});
    ram_wdata = in_data_i.word_high;
    if (st_q == StKeyLo) begin
      ram_we = 1'b1;
      ram_waddr = klo_addr_q;
      ram_wdata = klo_q;
    end
  end

  abm_ram #(.Width(64), .Depth(KeyWords)) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // step k reads key half k, in reversed round order when deciphering;
  // the last step repeats the final read so the data holds during a stall
  always_comb begin
    rstep = (step_q == CW'(KeyWords)) ? CW'(KeyWords - 1) : step_q;
    raddr = AW'(rstep);
    if (dec_q) raddr = AW'(KeyWords - 2) - AW'({rstep[CW-1:1], 1'b0}) + AW'(rstep[0]);
  end

  assign kfull = {khi_q, rdata};

  always_comb begin
    st_d = st_q;
    step_d = step_q;
    chain_d = chain_q;
    khi_d = khi_q;
    s_d = s_q;
    res_d = res_q;
    out_valid_d = out_valid_q;
    res_blk = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (step_q == CW'(2)) begin
      s_fin = s_q ^ kfull;
    end else if (!dec_q) begin
      s_fin = enc_round(s_q, step_q == CW'(KeyWords)) ^ kfull;
    end else begin
      s_fin = dec_round(s_q, kfull, step_q == CW'(KeyWords));
    end
    case (st_q)
      StRun: begin
        if (step_q[0]) khi_d = rdata;
        if (step_q != CW'(KeyWords)) begin
          step_d = step_q + CW'(1);
          if (step_q >= CW'(2) && !step_q[0]) s_d = s_fin;
        end else if (out_free) begin
          st_d = StIdle;
          out_valid_d = 1'b1;
          if (ctr_q) begin
            res_blk = s_fin ^ blk_q;
            for (int i = 0; i < 16; i++)
              if (5'(i) >= cnt_q) res_blk[127-8*i -: 8] = 8'h00;
            if (cnt_q == 5'(BlockBytes)) chain_d = chain_q + 128'd1;
          end else if (cbc_q && !dec_q) begin
            res_blk = s_fin;
            chain_d = s_fin;
          end else if (cbc_q) begin
            res_blk = s_fin ^ chain_q;
            chain_d = blk_q;
          end else begin
            res_blk = s_fin;
          end
          res_d = '{result_high: res_blk[127:64], result_low: res_blk[63:0]};
        end
      end
      StKeyLo: begin
        st_d = StIdle;
      end
      default: begin
        if (accept) begin
          if (in_data_i.mode == ModeData) begin
            st_d = StRun;
            step_d = '0;
          end else if (key_accept) begin
            st_d = StKeyLo;
          end else if (in_data_i.mode == ModeRestart) begin
            chain_d = iv_q;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      chain_q <= '0;
      chain_mode_q <= ChainEcb;
      dir_q <= 1'b0;
      iv_q <= '0;
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      chain_q <= chain_d;
      step_q <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgChainMode: chain_mode_q <= cfg_data_i[1:0];
          CfgDirection: dir_q <= cfg_data_i[0];
          CfgIvHigh:    iv_q[127:64] <= cfg_data_i;
          CfgIvLow:     iv_q[63:0] <= cfg_data_i;
          default:      ;
        endcase
      end
    end
  end

  assign ctr_in = (chain_mode_q == ChainCtr);
  assign cbc_in = (chain_mode_q == ChainCbc);
  always_comb begin
    blk_in = {in_data_i.word_high, in_data_i.word_low};
    if (ctr_in) blk_in = chain_q;
    else if (cbc_in && !dir_q) blk_in = blk_in ^ chain_q;
  end

  always_ff @(posedge clk_i) begin
    khi_q <= khi_d;
    res_q <= res_d;
    if (accept) begin
      s_q <= blk_in;
      blk_q <= {in_data_i.word_high, in_data_i.word_low};
      cnt_q <= (in_data_i.byte_count > 5'(BlockBytes)) ? 5'(BlockBytes) : in_data_i.byte_count;
      dec_q <= dir_q && !ctr_in;
      ctr_q <= ctr_in;
      cbc_q <= cbc_in;
      klo_q <= in_data_i.word_low;
      klo_addr_q <= AW'({in_data_i.key_index, 1'b1});
    end else begin
      s_q <= s_d;
    end
  end

  `AES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `AES_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != StIdle, !in_ready_o)
endmodule
`default_nettype wire
